// File: design/b64se_pkg.sv
`default_nettype none

package b64se_pkg;

    // queue between the byte front end and the character back end
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // character codes
    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam logic [7:0] CR_CHAR  = 8'h0D;
    localparam logic [7:0] LF_CHAR  = 8'h0A;

    // line length register
    localparam logic [7:0] LINE_LEN_RESET = 8'd76;
    localparam logic [7:0] MIN_LINE_LEN   = 8'd4;

    // position of the final character of a quad
    localparam logic [1:0] QUAD_LAST = 2'd3;

    // group phase codes
    localparam logic [1:0] PHASE_EMPTY = 2'd0;
    localparam logic [1:0] PHASE_ONE   = 2'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       end_of_message;
    } out_word_t;

    // one encoded quad, ready for output
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic            last;
    } quad_t;

    typedef enum logic {
        BK_CHAR,
        BK_LF
    } back_state_t;

    // standard base64 alphabet
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: design/b64se_front.sv
`default_nettype none

module b64se_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire b64se_pkg::in_word_t in_word,
    input  wire logic               q_full,
    output logic                    q_push,
    output b64se_pkg::quad_t        q_data
);
    import b64se_pkg::*;

    logic [15:0] held_reg;
    logic [15:0] held_next;
    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic        accept;
    logic        group_done;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b;
    logic [5:0]  s0;
    logic [5:0]  s1;
    logic [5:0]  s2;
    logic [5:0]  s3;

    // stall whenever the queue cannot take a quad
    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    assign b0 = held_reg[15:8];
    assign b1 = held_reg[7:0];
    assign b  = in_word.data_byte;

    // a quad goes out on a full group or at the message end
    assign group_done = phase_reg[1] || in_word.is_last;
    assign q_push     = accept && group_done;

    // sextet split for full group and tails
    always_comb
    begin
        s0 = b0[7:2];
        s1 = {b0[1:0], b1[7:4]};
        s2 = {b1[3:0], b[7:6]};
        s3 = b[5:0];
        q_data.last = in_word.is_last;
        if (phase_reg[1]) begin
            q_data.chars[0] = sextet_char(s0);
            q_data.chars[1] = sextet_char(s1);
            q_data.chars[2] = sextet_char(s2);
            q_data.chars[3] = sextet_char(s3);
        end else if (phase_reg == PHASE_EMPTY) begin
            s0 = b[7:2];
            s1 = {b[1:0], 4'b0000};
            q_data.chars[0] = sextet_char(s0);
            q_data.chars[1] = sextet_char(s1);
            q_data.chars[2] = PAD_CHAR;
            q_data.chars[3] = PAD_CHAR;
        end else begin
            s1 = {b0[1:0], b[7:4]};
            s2 = {b[3:0], 2'b00};
            q_data.chars[0] = sextet_char(s0);
            q_data.chars[1] = sextet_char(s1);
            q_data.chars[2] = sextet_char(s2);
            q_data.chars[3] = PAD_CHAR;
        end
    end

    // byte holding and phase
    always_comb
    begin
        held_next  = held_reg;
        phase_next = phase_reg;
        if (accept) begin
            if (group_done) begin
                held_next  = 16'h0000;
                phase_next = PHASE_EMPTY;
            end else if (phase_reg == PHASE_EMPTY) begin
                held_next  = {b, 8'h00};
                phase_next = PHASE_ONE;
            end else begin
                held_next  = {held_reg[15:8], b};
                phase_next = phase_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_reg  <= 16'h0000;
            phase_reg <= PHASE_EMPTY;
        end else begin
            held_reg  <= held_next;
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

// File: design/b64se_queue.sv
`default_nettype none

module b64se_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire b64se_pkg::quad_t push_data,
    input  wire logic             pop,
    output logic                  full,
    output logic                  not_empty,
    output b64se_pkg::quad_t      head
);
    import b64se_pkg::*;

    quad_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               do_push;
    logic               do_pop;

    assign full      = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: design/b64se_back.sv
`default_nettype none

module b64se_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [7:0]       line_length,
    input  wire logic             q_valid,
    input  wire b64se_pkg::quad_t q_head,
    output logic                  q_pop,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output b64se_pkg::out_word_t  out_word
);
    import b64se_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    out_word_t   out_word_reg;
    out_word_t   out_word_next;
    logic [7:0]  col_reg;
    logic [7:0]  col_next;
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;
    logic [7:0]  limit;
    logic        brk;
    logic        adv;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // effective line length and break test
    assign limit = (line_length != 8'd0 && line_length < MIN_LINE_LEN) ? MIN_LINE_LEN
                                                                        : line_length;
    assign brk   = (limit != 8'd0) && (col_reg >= limit);
    assign adv   = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_CHAR:
            begin
                if (adv && q_valid && brk) begin
                    state_next = BK_LF;
                end
            end
            BK_LF:
            begin
                if (adv) begin
                    state_next = BK_CHAR;
                end
            end
            default:
            begin
                state_next = BK_CHAR;
            end
        endcase
    end

    // output word, column and quad position
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;
        col_next       = col_reg;
        idx_next       = idx_reg;
        q_pop          = 1'b0;
        case (state_reg)
            BK_CHAR:
            begin
                if (adv && q_valid) begin
                    out_valid_next = 1'b1;
                    if (brk) begin
                        out_word_next.out_char       = CR_CHAR;
                        out_word_next.end_of_message = 1'b0;
                        col_next                     = 8'd0;
                    end else begin
                        out_word_next.out_char       = q_head.chars[idx_reg];
                        out_word_next.end_of_message = q_head.last && (idx_reg == QUAD_LAST);
                        col_next                     = col_reg + 8'd1;
                        if (idx_reg == QUAD_LAST) begin
                            idx_next = 2'd0;
                            q_pop    = 1'b1;
                            if (q_head.last) begin
                                col_next = 8'd0;
                            end
                        end else begin
                            idx_next = idx_reg + 2'd1;
                        end
                    end
                end
            end
            BK_LF:
            begin
                if (adv) begin
                    out_valid_next               = 1'b1;
                    out_word_next.out_char       = LF_CHAR;
                    out_word_next.end_of_message = 1'b0;
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= BK_CHAR;
            out_valid_reg <= 1'b0;
            col_reg       <= 8'd0;
            idx_reg       <= 2'd0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            col_reg       <= col_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    // a pending line feed always sits behind a waiting carriage return
    a_lf_after_cr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_LF |-> out_valid_reg && out_word_reg.out_char == CR_CHAR)
        else $error("line feed pending without carriage return in output");

    // the head quad stays while its characters are partly sent
    a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != 2'd0 |-> q_valid)
        else $error("queue head lost in the middle of a quad");

    // message end never marks a line break character
    a_eom_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_word_reg.end_of_message |->
            out_word_reg.out_char != CR_CHAR && out_word_reg.out_char != LF_CHAR)
        else $error("end of message on a line break");

    // a quad leaves the queue only on its final character
    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> idx_reg == QUAD_LAST && state_reg == BK_CHAR)
        else $error("quad popped before its final character");

endmodule

`default_nettype wire

// File: design/base64_stream_encoder.sv
// base64 encoder with line breaks, one byte in per word, one character out per word
// path: the quad of the byte that completes it is written into the quad queue, then its first character is registered
// throughput: one output character per cycle while out_stall is low, four characters per three bytes plus CR and LF
// per line break; the output sequencer paces this, input stalls only while the two-entry quad queue is full
// reset: rst_n clears held bytes, phase, column and queue at once; line_length returns to 76
`default_nettype none

module base64_stream_encoder (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire b64se_pkg::in_word_t  in_word,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output b64se_pkg::out_word_t      out_word,
    input  wire logic                 cfg_write_en,
    input  wire logic [7:0]           cfg_write_data
);
    import b64se_pkg::*;

    logic [7:0] line_length_reg;
    logic [7:0] line_length_next;
    logic       q_full;
    logic       q_push;
    quad_t      q_push_data;
    logic       q_pop;
    logic       q_not_empty;
    quad_t      q_head;

    // line length register
    assign line_length_next = cfg_write_en ? cfg_write_data : line_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            line_length_reg <= LINE_LEN_RESET;
        end else begin
            line_length_reg <= line_length_next;
        end
    end

    // byte grouping and character lookup
    b64se_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_push_data)
    );

    // quad queue
    b64se_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // character sequencer with line breaks
    b64se_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .line_length (line_length_reg),
        .q_valid     (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_word    (out_word)
    );

endmodule

`default_nettype wire

// File: test/base64_stream_encoder_tb.sv
`timescale 1ns / 1ps

module base64_stream_encoder_tb;
    import b64se_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int FLOOD_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int N_DIRECTED    = 21;
    localparam int N_PHASES      = 12;
    localparam int N_FIXED       = 10;
    localparam int FLOOD_PHASE   = 2;
    localparam int PHASE_WORDS   = 22;
    localparam int WIDE_WORDS    = 215;
    localparam int WIDE_MSG      = 230;
    localparam int BURST_MAX     = 17;
    localparam logic [7:0] WIDEST_LINE = 8'd255;

    // first symbol sits in the top byte
    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_last;
        logic        typed;
        logic [31:0] quad;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_word_t    in_word;
    logic        out_valid;
    logic        out_stall;
    out_word_t   out_word;
    logic        cfg_write_en;
    logic [7:0]  cfg_write_data;

    // encoder state as predicted
    logic [15:0] pend_bytes;
    logic [1:0]  pend_count;
    logic [7:0]  line_col;
    logic [7:0]  line_len;
    out_word_t   step_words[$];
    out_word_t   expected_chars[$];
    out_word_t   exp_w;

    stim_row_t   directed_rows [N_DIRECTED];
    logic [7:0]  fixed_len [N_FIXED];

    int          errors;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          calm;
    bit          flood_req;
    bit          flood_done;
    int          flood_left;
    int          stall_left;

    base64_stream_encoder u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_word        (in_word),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_word       (out_word),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic logic [7:0] b64_symbol(input logic [5:0] v);
        return ALPHABET[8 * (63 - int'(v)) +: 8];
    endfunction

    // one character onto the line, with a break first when the line is full
    function void put_char(input logic [7:0] ch, input logic eom);
        logic [7:0] limit;
        out_word_t  w;
        limit = line_len;
        if (limit != 8'd0 && limit < MIN_LINE_LEN)
            limit = MIN_LINE_LEN;
        if (limit != 8'd0 && line_col >= limit)
        begin
            w.out_char = CR_CHAR;
            w.end_of_message = 1'b0;
            step_words.push_back(w);
            w.out_char = LF_CHAR;
            step_words.push_back(w);
            line_col = 8'd0;
        end
        w.out_char = ch;
        w.end_of_message = eom;
        step_words.push_back(w);
        line_col = line_col + 8'd1;
    endfunction

    // characters caused by one accepted byte
    function void encode_byte(input logic [7:0] b, input logic last);
        logic [7:0] b0;
        logic [7:0] b1;
        step_words.delete();
        b0 = pend_bytes[15:8];
        b1 = pend_bytes[7:0];
        if (pend_count >= 2'd2)
        begin
            put_char(b64_symbol(b0[7:2]), 1'b0);
            put_char(b64_symbol({b0[1:0], b1[7:4]}), 1'b0);
            put_char(b64_symbol({b1[3:0], b[7:6]}), 1'b0);
            put_char(b64_symbol(b[5:0]), last);
        end
        else if (last && pend_count == PHASE_EMPTY)
        begin
            put_char(b64_symbol(b[7:2]), 1'b0);
            put_char(b64_symbol({b[1:0], 4'h0}), 1'b0);
            put_char(PAD_CHAR, 1'b0);
            put_char(PAD_CHAR, 1'b1);
        end
        else if (last)
        begin
            put_char(b64_symbol(b0[7:2]), 1'b0);
            put_char(b64_symbol({b0[1:0], b[7:4]}), 1'b0);
            put_char(b64_symbol({b[3:0], 2'b00}), 1'b0);
            put_char(PAD_CHAR, 1'b1);
        end
        else
        begin
            if (pend_count == PHASE_EMPTY)
                pend_bytes = {b, 8'h00};
            else
                pend_bytes[7:0] = b;
            pend_count = pend_count + 2'd1;
            return;
        end
        pend_bytes = 16'h0000;
        pend_count = PHASE_EMPTY;
        if (last)
            line_col = 8'd0;
    endfunction

    // offer one word and record what it should produce
    task automatic send_word(input logic [7:0] b, input logic last, input logic typed,
                             input logic [31:0] quad);
        out_word_t w;
        in_word <= '{data_byte: b, is_last: last};
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        encode_byte(b, last);
        if (typed)
        begin
            for (int i = 0; i < 4; i++)
            begin
                w.out_char = quad[8 * (3 - i) +: 8];
                w.end_of_message = last && (i == 3);
                expected_chars.push_back(w);
            end
        end
        else
        begin
            foreach (step_words[i])
                expected_chars.push_back(step_words[i]);
        end
    endtask

    task automatic sender_gap();
        if (!calm && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, BURST_MAX)) @(posedge clk);
        end
    endtask

    // wait until the encoder is empty, then load a new line length
    task automatic write_line_len(input logic [7:0] v);
        in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        line_len = v;
    endtask

    function automatic int pick_rate();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 15;
            default: return 50;
        endcase
    endfunction

    // receiver: random stall bursts, one long hold-off on request
    always @(posedge clk)
    begin
        if (flood_req && !flood_done)
        begin
            flood_done = 1'b1;
            flood_left = FLOOD_CYCLES;
        end
        if (flood_left > 0)
        begin
            flood_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 99) < recv_idle_pct)
        begin
            stall_left = $urandom_range(1, BURST_MAX) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // compare each accepted character word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none, got char %h eom %b",
                         $time, out_word.out_char, out_word.end_of_message);
            end
            else
            begin
                exp_w = expected_chars.pop_front();
                if (out_word.out_char !== exp_w.out_char)
                begin
                    errors++;
                    $display("%0t: out_char expected %h got %h",
                             $time, exp_w.out_char, out_word.out_char);
                end
                if (out_word.end_of_message !== exp_w.end_of_message)
                begin
                    errors++;
                    $display("%0t: end_of_message expected %b got %b",
                             $time, exp_w.end_of_message, out_word.end_of_message);
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int         msg_left;
        int         n_words;
        logic [7:0] cfg_v;

        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        out_stall = 1'b0;
        cfg_write_en = 1'b0;
        cfg_write_data = 8'd0;
        errors = 0;
        cycle_count = 0;
        calm = 1'b0;
        flood_req = 1'b0;
        flood_done = 1'b0;
        flood_left = 0;
        stall_left = 0;
        send_idle_pct = 20;
        recv_idle_pct = 20;
        msg_left = 0;

        pend_bytes = 16'h0000;
        pend_count = PHASE_EMPTY;
        line_col = 8'd0;
        line_len = LINE_LEN_RESET;

        // tails, full groups and byte extremes, all on the first line after reset
        directed_rows = '{
            '{8'h00, 1'b1, 1'b1, "AA=="},
            '{8'hFF, 1'b1, 1'b1, "/w=="},
            '{8'h00, 1'b0, 1'b0, 32'h0},
            '{8'h00, 1'b0, 1'b0, 32'h0},
            '{8'h00, 1'b1, 1'b1, "AAAA"},
            '{8'hFF, 1'b0, 1'b0, 32'h0},
            '{8'hFF, 1'b0, 1'b0, 32'h0},
            '{8'hFF, 1'b1, 1'b1, "////"},
            '{8'hFF, 1'b0, 1'b0, 32'h0},
            '{8'hFF, 1'b1, 1'b1, "//8="},
            '{8'h00, 1'b0, 1'b0, 32'h0},
            '{8'h00, 1'b1, 1'b1, "AAA="},
            '{8'h4D, 1'b0, 1'b0, 32'h0},
            '{8'h61, 1'b0, 1'b0, 32'h0},
            '{8'h6E, 1'b0, 1'b0, 32'h0},
            '{8'h01, 1'b0, 1'b0, 32'h0},
            '{8'h80, 1'b1, 1'b0, 32'h0},
            '{8'hA5, 1'b0, 1'b0, 32'h0},
            '{8'h5A, 1'b0, 1'b0, 32'h0},
            '{8'h3C, 1'b0, 1'b0, 32'h0},
            '{8'hC3, 1'b1, 1'b0, 32'h0}
        };
        fixed_len = '{8'd4, 8'd0, 8'd1, WIDEST_LINE, 8'd2, 8'd3, 8'd77, 8'd5,
                      LINE_LEN_RESET, 8'd8};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words at the reset line length
        for (int r = 0; r < N_DIRECTED; r++)
        begin
            send_word(directed_rows[r].data_byte, directed_rows[r].is_last,
                      directed_rows[r].typed, directed_rows[r].quad);
            sender_gap();
        end

        // random messages, line length changed between phases, often mid-message
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            cfg_v = (ph < N_FIXED) ? fixed_len[ph] : 8'($urandom_range(0, 255));
            write_line_len(cfg_v);
            calm = (ph == N_PHASES - 1);
            send_idle_pct = pick_rate();
            recv_idle_pct = pick_rate();
            if (ph == FLOOD_PHASE)
                flood_req = 1'b1;
            n_words = PHASE_WORDS;
            if (ph < N_FIXED && cfg_v == WIDEST_LINE)
            begin
                // one long message so the widest line actually wraps
                n_words = WIDE_WORDS;
                if (msg_left < WIDE_MSG)
                    msg_left = WIDE_MSG;
            end
            repeat (n_words)
            begin
                if (msg_left == 0)
                    msg_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                           : $urandom_range(1, 12);
                send_word(8'($urandom_range(0, 255)), msg_left == 1, 1'b0, 32'h0);
                msg_left--;
                sender_gap();
            end
        end

        in_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES * 4) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
design/b64se_pkg.sv
design/b64se_front.sv
design/b64se_queue.sv
design/b64se_back.sv
design/base64_stream_encoder.sv
test/base64_stream_encoder_tb.sv
